// ===== rtl/core/spdc_pkg.sv =====
// Shared types, codes and the CRC-8 byte step for the serial packet deframer.
// No dependencies; imported by every module of the core.
`default_nettype none

package spdc_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // Frame phases
  localparam logic [1:0] PH_SYNC    = 2'd0;
  localparam logic [1:0] PH_LEN     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_CHECK   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYNC_BYTE     = 2'd0;
  localparam logic [1:0] CFG_START_COMMAND = 2'd1;
  localparam logic [1:0] CFG_ECHO_COMMAND  = 2'd2;

  localparam logic [7:0]  SYNC_RESET  = 8'h5a;
  localparam logic [7:0]  START_RESET = 8'hf0;
  localparam logic [7:0]  ECHO_RESET  = 8'h45;
  localparam logic [7:0]  CRC_POLY    = 8'h9d;
  localparam logic [15:0] ECHO_MAX    = 16'hffff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  position;
    logic [7:0]  frame_command;
    logic        ping_on;
    logic [15:0] echo_total;
  } spdc_result_t;

  // One byte of the reflected CRC-8, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] dat_in);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = dat_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[0]) begin
        c = c ^ CRC_POLY;
      end
      c = c >> 1;
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/serial_packet_deframer_crc8_core.sv =====
// Top level of the serial packet deframer; instantiates spdc_frame_fsm and
// spdc_out_stage, uses spdc_pkg.
`default_nettype none

// Deframes a byte stream: waits for the sync byte, reads a length byte, then
// that many payload bytes and a CRC-8 check byte (poly 0x9d reflected, seed
// zero, over length and payload). Each payload byte yields one result; the
// check byte yields an accepted or rejected result; sync, length and idle
// bytes yield none. Throughput is one byte per clock while the output is not
// stalled: a byte waits in the input register, is processed by the
// combinational frame logic and lands in the result register. The input side
// stalls only when the result register is full and stalled. Configuration
// writes must happen while no transaction is in flight.
module serial_packet_deframer_crc8_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data,
  output logic [7:0]       out_position,
  output logic [7:0]       out_frame_command,
  output logic             out_ping_on,
  output logic [15:0]      out_echo_total
);
  import spdc_pkg::*;

  logic         in_valid_r, in_valid_nxt;
  logic [7:0]   in_byte_r;
  logic         can_take, fire, in_accept;
  logic         res_valid;
  spdc_result_t res, out_res;

  // Input register
  assign fire      = in_valid_r && can_take;
  assign in_stall  = in_valid_r && !can_take;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_rx_byte;
    end
  end

  spdc_frame_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step_en   (fire),
    .step_byte (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  spdc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_data          = out_res.data;
  assign out_position      = out_res.position;
  assign out_frame_command = out_res.frame_command;
  assign out_ping_on       = out_res.ping_on;
  assign out_echo_total    = out_res.echo_total;

  // A processed byte that produces a result shows up on the output next cycle
  a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> out_valid)
    else $error("result of a processed byte was not registered");

  // A held input byte is never dropped while waiting for the output
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r)
    else $error("pending input transaction lost");

  // Results carry only defined kinds
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_PAYLOAD || out_kind == KIND_ACCEPT ||
                   out_kind == KIND_REJECT))
    else $error("undefined result kind");

endmodule

`default_nettype wire

// ===== rtl/core/spdc_frame_fsm.sv =====
// Frame state machine: sync/length/payload/check tracking, CRC, ping/echo
// bookkeeping and the configuration registers. Depends on spdc_pkg.
`default_nettype none

module spdc_frame_fsm (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  input  wire logic                 step_en,
  input  wire logic [7:0]           step_byte,
  output logic                      res_valid,
  output spdc_pkg::spdc_result_t    res
);
  import spdc_pkg::*;

  logic [7:0]  sync_byte_r, start_cmd_r, echo_cmd_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  byte_idx_r, byte_idx_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic        ping_r, ping_nxt;
  logic [15:0] echo_r, echo_nxt;
  logic [7:0]  crc_step;

  // CRC over the current byte, seeded with zero on the length byte
  assign crc_step = crc8_byte((phase_r == PH_LEN) ? 8'd0 : crc_r, step_byte);

  // Next-state logic
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    byte_idx_nxt   = byte_idx_r;
    cmd_nxt        = cmd_r;
    ping_nxt       = ping_r;
    echo_nxt       = echo_r;
    res_valid      = 1'b0;
    res.kind       = KIND_PAYLOAD;
    res.data       = step_byte;
    res.position   = 8'd0;
    unique case (phase_r)
      PH_SYNC: begin
        if (step_byte == sync_byte_r) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (step_byte == 8'd0) begin
          phase_nxt = PH_SYNC;
        end else begin
          bytes_left_nxt = step_byte;
          crc_nxt        = crc_step;
          byte_idx_nxt   = 8'd0;
          phase_nxt      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_nxt        = crc_step;
        byte_idx_nxt   = byte_idx_r + 8'd1;
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (byte_idx_r == 8'd0) begin
          cmd_nxt = step_byte;
        end
        if (bytes_left_r == 8'd1) begin
          phase_nxt = PH_CHECK;
        end
        res_valid    = 1'b1;
        res.position = byte_idx_r;
      end
      PH_CHECK: begin
        phase_nxt = PH_SYNC;
        res_valid = 1'b1;
        if (crc_r == step_byte) begin
          res.kind = KIND_ACCEPT;
          if (cmd_r == start_cmd_r && !ping_r) begin
            ping_nxt = 1'b1;
            echo_nxt = 16'd0;
          end else if (ping_r && cmd_r == echo_cmd_r && echo_r != ECHO_MAX) begin
            echo_nxt = echo_r + 16'd1;
          end
        end else begin
          res.kind = KIND_REJECT;
        end
      end
      default: phase_nxt = PH_SYNC;
    endcase
    // Reported status reflects the state after this byte
    res.frame_command = cmd_nxt;
    res.ping_on       = ping_nxt;
    res.echo_total    = echo_nxt;
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SYNC;
      bytes_left_r <= 8'd0;
      crc_r        <= 8'd0;
      byte_idx_r   <= 8'd0;
      cmd_r        <= 8'd0;
      ping_r       <= 1'b0;
      echo_r       <= 16'd0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      crc_r        <= crc_nxt;
      byte_idx_r   <= byte_idx_nxt;
      cmd_r        <= cmd_nxt;
      ping_r       <= ping_nxt;
      echo_r       <= echo_nxt;
    end
  end

  // Configuration registers; index 3 is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= SYNC_RESET;
      start_cmd_r <= START_RESET;
      echo_cmd_r  <= ECHO_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SYNC_BYTE:     sync_byte_r <= cfg_wdata;
        CFG_START_COMMAND: start_cmd_r <= cfg_wdata;
        CFG_ECHO_COMMAND:  echo_cmd_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spdc_out_stage.sv =====
// Result register with valid/stall handshake toward the consumer.
// Depends on spdc_pkg for the result struct.
`default_nettype none

module spdc_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic                 res_valid,
  input  wire spdc_pkg::spdc_result_t res,
  input  wire logic                 out_stall,
  output logic                      can_take,
  output logic                      out_valid,
  output spdc_pkg::spdc_result_t    out_res
);
  import spdc_pkg::*;

  logic         valid_r, valid_nxt;
  spdc_result_t res_r;

  // Register is free when empty or being drained this cycle
  assign can_take = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire
